// ----- src/tlpic_pkg.sv -----
// ----------------------------------------------------------------------------
// tlpic_pkg
// Shared types and constants for the two-level priority interrupt control.
// ----------------------------------------------------------------------------
`default_nettype none

package tlpic_pkg;

   // Control register bit positions
   localparam int unsigned BIT_GIE  = 7;   // GIE / GIEH
   localparam int unsigned BIT_PEIE = 6;   // PEIE / GIEL
   localparam int unsigned BIT_T0IF = 2;   // timer flag

   localparam int unsigned REG_W     = 8;
   localparam int unsigned MODE_W    = 3;
   localparam int unsigned PSTAT_W   = 2;
   localparam int unsigned PSEL_W    = 2;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DAT_W = 2;

   localparam logic [PSEL_W-1:0] PSEL_RESET = 2'b11;

   // Operation codes
   typedef enum logic [MODE_W-1:0] {
      MODE_WRITE  = 3'd0,
      MODE_RETURN = 3'd1,
      MODE_ENTRY  = 3'd2,
      MODE_PERIPH = 3'd3,
      MODE_TIMER  = 3'd4
   } mode_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PRIORITY_ENABLE = 1'b0,
      CSR_PRIORITY_SELECT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [REG_W-1:0] control_bits;
      logic             vector_is_high;
   } state_type;

   typedef struct packed {
      logic              priority_enable;
      logic [PSEL_W-1:0] priority_select;
   } cfg_type;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [REG_W-1:0]   write_data;
      logic [PSTAT_W-1:0] peripheral_status;
      logic               high_request;
      logic               in_service;
   } item_type;

   typedef struct packed {
      state_type next_state;
      logic      interrupt_request;
   } eval_type;

endpackage

`default_nettype wire

// ----- src/tlpic_req_if.sv -----
// ----------------------------------------------------------------------------
// tlpic_req_if
// Operation channel: one item per accepted valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlpic_req_if;
   import tlpic_pkg::*;

   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  mode;
   logic [REG_W-1:0]   write_data;
   logic [PSTAT_W-1:0] peripheral_status;
   logic               high_request;
   logic               in_service;

   modport source (output valid, mode, write_data, peripheral_status, high_request,
                   in_service, input ready);
   modport sink   (input valid, mode, write_data, peripheral_status, high_request,
                   in_service, output ready);
endinterface

`default_nettype wire

// ----- src/tlpic_rsp_if.sv -----
// ----------------------------------------------------------------------------
// tlpic_rsp_if
// Result channel: register contents, request and vector per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlpic_rsp_if;
   import tlpic_pkg::*;

   logic             valid;
   logic             ready;
   logic [REG_W-1:0] register_value;
   logic             interrupt_request;
   logic             vector_high;

   modport source (output valid, register_value, interrupt_request, vector_high,
                   input ready);
   modport sink   (input valid, register_value, interrupt_request, vector_high,
                   output ready);
endinterface

`default_nettype wire

// ----- src/tlpic_csr_if.sv -----
// ----------------------------------------------------------------------------
// tlpic_csr_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlpic_csr_if;
   import tlpic_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- src/tlpic_eval.sv -----
// ----------------------------------------------------------------------------
// tlpic_eval
// Applies one operation to the control register and evaluates the pending
// sources against the global and peripheral enables.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpic_eval (
   input  tlpic_pkg::state_type state,
   input  tlpic_pkg::cfg_type   cfg,
   input  tlpic_pkg::item_type  item,
   output tlpic_pkg::eval_type  result
);
   import tlpic_pkg::*;

   typedef struct packed {
      logic req;
      logic vih;
   } check_type;

   // Evaluate sources after the register takes value v
   function automatic check_type write_check(input logic [REG_W-1:0] v,
                                             input logic [PSTAT_W-1:0] pstat,
                                             input logic busy,
                                             input cfg_type c,
                                             input logic vih);
      logic [2:0] active;
      logic [2:0] hmask;
      logic [2:0] lmask;
      check_type  r;
      active = v[5:3] & v[2:0];
      hmask  = {c.priority_select[1], 1'b1, c.priority_select[0]};
      lmask  = {~c.priority_select[1], 1'b0, ~c.priority_select[0]};
      r.req  = 1'b0;
      r.vih  = vih;
      if (c.priority_enable) begin
         if (v[BIT_GIE] && !busy) begin
            if ((|(active & hmask)) || pstat[1]) begin
               r.req = 1'b1;
               r.vih = 1'b1;
            end else if (((|(active & lmask)) || pstat[0]) && v[BIT_PEIE]) begin
               r.req = 1'b1;
               r.vih = 1'b0;
            end
         end
      end else begin
         r.vih = 1'b1;
         r.req = v[BIT_GIE] && !busy && ((|active) || (v[BIT_PEIE] && (|pstat)));
      end
      return r;
   endfunction

   logic             do_write;
   logic [REG_W-1:0] wr_value;
   check_type        chk;
   logic             gate_both;

   assign gate_both = state.control_bits[BIT_GIE] && state.control_bits[BIT_PEIE];

   // Pick the new register value for the writing operations
   always_comb begin
      do_write = 1'b1;
      wr_value = state.control_bits;
      case (item.mode)
         MODE_WRITE: begin
            wr_value = item.write_data;
         end
         MODE_RETURN: begin
            if (cfg.priority_enable && state.control_bits[BIT_GIE]) begin
               wr_value[BIT_PEIE] = 1'b1;
            end else begin
               wr_value[BIT_GIE] = 1'b1;
            end
         end
         MODE_ENTRY: begin
            if (!cfg.priority_enable || state.vector_is_high) begin
               wr_value[BIT_GIE] = 1'b0;
            end else begin
               wr_value[BIT_PEIE] = 1'b0;
            end
         end
         MODE_TIMER: begin
            wr_value[BIT_T0IF] = 1'b1;
         end
         default: begin
            do_write = 1'b0;
         end
      endcase
   end

   assign chk = write_check(wr_value, item.peripheral_status, item.in_service, cfg,
                            state.vector_is_high);

   // Merge the writing path with the peripheral request path
   always_comb begin
      result.next_state        = state;
      result.interrupt_request = 1'b0;
      if (do_write) begin
         result.next_state.control_bits   = wr_value;
         result.next_state.vector_is_high = chk.vih;
         result.interrupt_request         = chk.req;
      end else if (item.mode == MODE_PERIPH && !item.in_service) begin
         if (cfg.priority_enable) begin
            if (item.high_request) begin
               if (state.control_bits[BIT_GIE]) begin
                  result.next_state.vector_is_high = 1'b1;
                  result.interrupt_request         = 1'b1;
               end
            end else if (gate_both) begin
               result.next_state.vector_is_high = 1'b0;
               result.interrupt_request         = 1'b1;
            end
         end else begin
            result.interrupt_request = gate_both;
         end
      end
   end

endmodule

`default_nettype wire

// ----- src/two_level_priority_interrupt_control.sv -----
// ----------------------------------------------------------------------------
// two_level_priority_interrupt_control
// Interrupt control register with single-level or two-level priority
// gating, vector selection and entry/return enable handling.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake      | payload
//  req_ch   | in  | valid / ready  | mode, write_data, peripheral_status,
//           |     |                | high_request, in_service
//  rsp_ch   | out | valid / ready  | register_value, interrupt_request,
//           |     |                | vector_high
//  csr_ch   | in  | valid / ready  | index (0 priority_enable,
//           |     |                | 1 priority_select), data
//
//  One item per cycle while rsp_ch accepts results; its result shows in the cycle after acceptance.
//  The control state and the result register load in the same cycle from
//  one level of evaluation logic, so consecutive items chain directly.
//  req_ch.ready drops only while a result is held and rsp_ch.ready is low.
//  csr_ch is always ready. Reset clears the register, the vector and
//  priority_enable, and sets priority_select to 3.
// ----------------------------------------------------------------------------
`default_nettype none

module two_level_priority_interrupt_control (
   input wire logic   clock,
   input wire logic   reset,
   tlpic_req_if.sink   req_ch,
   tlpic_rsp_if.source rsp_ch,
   tlpic_csr_if.sink   csr_ch
);
   import tlpic_pkg::*;

   state_type        state_ff;
   cfg_type          cfg_ff;
   cfg_type          cfg_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [REG_W-1:0] rsp_reg_ff;
   logic             rsp_irq_ff;
   logic             rsp_vec_ff;
   item_type         item;
   eval_type         eval;
   logic             req_fire;
   logic             rsp_fire;

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_fire     = rsp_valid_ff && rsp_ch.ready;

   assign item.mode              = req_ch.mode;
   assign item.write_data        = req_ch.write_data;
   assign item.peripheral_status = req_ch.peripheral_status;
   assign item.high_request      = req_ch.high_request;
   assign item.in_service        = req_ch.in_service;

   tlpic_eval u_eval (
      .state  (state_ff),
      .cfg    (cfg_ff),
      .item   (item),
      .result (eval)
   );

   // Decode configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_PRIORITY_ENABLE: cfg_in.priority_enable = csr_ch.data[0];
            CSR_PRIORITY_SELECT: cfg_in.priority_select = csr_ch.data[PSEL_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff                 <= '0;
         cfg_ff.priority_enable   <= 1'b0;
         cfg_ff.priority_select   <= PSEL_RESET;
         rsp_valid_ff             <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            state_ff <= eval.next_state;
         end
      end
   end

   // Result register, loaded with each accepted item
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_reg_ff <= eval.next_state.control_bits;
         rsp_irq_ff <= eval.interrupt_request;
         rsp_vec_ff <= eval.next_state.vector_is_high;
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.register_value    = rsp_reg_ff;
   assign rsp_ch.interrupt_request = rsp_irq_ff;
   assign rsp_ch.vector_high       = rsp_vec_ff;

   // Every accepted item leaves a result behind
   a_item_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted item produced no result");

   // A held result always reflects the live control state
   a_result_tracks_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_reg_ff == state_ff.control_bits &&
                        rsp_vec_ff == state_ff.vector_is_high))
      else $error("held result differs from control state");

   // A request is only raised with the global enable set
   a_irq_needs_gie: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_irq_ff) |-> rsp_reg_ff[BIT_GIE])
      else $error("interrupt raised with GIE clear");

   // A low-vector request needs the peripheral/low enable
   a_low_needs_giel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_irq_ff && !rsp_vec_ff) |-> rsp_reg_ff[BIT_PEIE])
      else $error("low vector request with GIEL clear");

endmodule

`default_nettype wire

// ----- bench/tb_two_level_priority_interrupt_control.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_two_level_priority_interrupt_control
// Self-checking bench for the interrupt control register. Items go in on the
// operation channel and the priority settings go in on the csr channel. An
// in-bench model of the register, the vector and the gating predicts each
// result, and a checker compares each result with the oldest prediction.
// Directed cases come first, then random items under several priority
// settings and idle patterns, and a long receiver hold-off that backs up the
// block.
// ----------------------------------------------------------------------------

module tb_two_level_priority_interrupt_control;
   import tlpic_pkg::*;

   // Flag positions within the low three bits (timer, external, change)
   localparam logic [2:0] FLAG_TIMER  = 3'b100;
   localparam logic [2:0] FLAG_EXT    = 3'b010;
   localparam logic [2:0] FLAG_CHANGE = 3'b001;

   localparam logic [REG_W-1:0] MASK_GIE  = 8'b1 << BIT_GIE;
   localparam logic [REG_W-1:0] MASK_PEIE = 8'b1 << BIT_PEIE;
   localparam logic [REG_W-1:0] MASK_T0IF = 8'b1 << BIT_T0IF;

   // Mode codes that the block ignores
   localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
   localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

   localparam int DRAIN_GUARD = 5000;
   localparam int HOLD_CYCLES = 60;

   typedef struct packed {
      logic [REG_W-1:0] register_value;
      logic             interrupt_request;
      logic             vector_high;
   } result_type;

   logic clock;
   logic reset;

   tlpic_req_if req_if ();
   tlpic_rsp_if rsp_if ();
   tlpic_csr_if csr_if ();

   two_level_priority_interrupt_control u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // Model state and settings
   logic [REG_W-1:0]  ctrl_q;
   logic              vec_hi_q;
   logic              prio_en_q;
   logic [PSEL_W-1:0] prio_sel_q;

   result_type expected_q[$];
   int         err_count = 0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // Hold-off request: main sets the length and toggles the go bit
   int hold_len = 0;
   bit hold_go  = 1'b0;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Limit on run length
   initial begin
      #3_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // Report one mismatch and count it
   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      err_count++;
   endtask

   // Load the register and evaluate pending sources; returns the request
   function automatic logic load_and_evaluate(logic [REG_W-1:0] value,
                                              logic [PSTAT_W-1:0] pstat, logic busy);
      logic [2:0] active;
      logic [2:0] hmask;
      logic [2:0] lmask;
      ctrl_q = value;
      active = ctrl_q[5:3] & ctrl_q[2:0];
      if (prio_en_q) begin
         hmask = FLAG_EXT | (prio_sel_q[1] ? FLAG_TIMER : 3'b000)
                          | (prio_sel_q[0] ? FLAG_CHANGE : 3'b000);
         lmask = (FLAG_TIMER | FLAG_CHANGE) & ~hmask;
         if (!ctrl_q[BIT_GIE] || busy)
            return 1'b0;
         if ((active & hmask) != 3'b000 || pstat[1]) begin
            vec_hi_q = 1'b1;
            return 1'b1;
         end
         if (((active & lmask) != 3'b000 || pstat[0]) && ctrl_q[BIT_PEIE]) begin
            vec_hi_q = 1'b0;
            return 1'b1;
         end
         return 1'b0;
      end
      // Single level: vector forced high on every load
      vec_hi_q = 1'b1;
      if (ctrl_q[BIT_GIE] && !busy) begin
         if (active != 3'b000)
            return 1'b1;
         if (ctrl_q[BIT_PEIE] && pstat != '0)
            return 1'b1;
      end
      return 1'b0;
   endfunction

   // Apply one operation to the model and return the expected result
   function automatic result_type predict_control(item_type it);
      result_type r;
      logic       irq;
      irq = 1'b0;
      case (it.mode)
         MODE_WRITE: begin
            irq = load_and_evaluate(it.write_data, it.peripheral_status, it.in_service);
         end
         MODE_RETURN: begin
            if (prio_en_q && ctrl_q[BIT_GIE])
               irq = load_and_evaluate(ctrl_q | MASK_PEIE, it.peripheral_status,
                                       it.in_service);
            else
               irq = load_and_evaluate(ctrl_q | MASK_GIE, it.peripheral_status,
                                       it.in_service);
         end
         MODE_ENTRY: begin
            if (!prio_en_q || vec_hi_q)
               irq = load_and_evaluate(ctrl_q & ~MASK_GIE, it.peripheral_status,
                                       it.in_service);
            else
               irq = load_and_evaluate(ctrl_q & ~MASK_PEIE, it.peripheral_status,
                                       it.in_service);
         end
         MODE_PERIPH: begin
            if (prio_en_q) begin
               if (it.high_request) begin
                  if (ctrl_q[BIT_GIE] && !it.in_service) begin
                     vec_hi_q = 1'b1;
                     irq      = 1'b1;
                  end
               end else if (ctrl_q[BIT_GIE] && ctrl_q[BIT_PEIE] && !it.in_service) begin
                  vec_hi_q = 1'b0;
                  irq      = 1'b1;
               end
            end else if (ctrl_q[BIT_GIE] && ctrl_q[BIT_PEIE] && !it.in_service) begin
               irq = 1'b1;
            end
         end
         MODE_TIMER: begin
            irq = load_and_evaluate(ctrl_q | MASK_T0IF, it.peripheral_status, it.in_service);
         end
         default: begin
         end
      endcase
      r.register_value    = ctrl_q;
      r.interrupt_request = irq;
      r.vector_high       = vec_hi_q;
      return r;
   endfunction

   function automatic item_type make_item(logic [MODE_W-1:0] mode, logic [REG_W-1:0] wdata,
                                          logic [PSTAT_W-1:0] pstat, logic hreq,
                                          logic busy);
      item_type it;
      it.mode              = mode;
      it.write_data        = wdata;
      it.peripheral_status = pstat;
      it.high_request      = hreq;
      it.in_service        = busy;
      return it;
   endfunction

   function automatic item_type random_item();
      item_type it;
      if ($urandom_range(99) < 12)
         it.mode = MODE_W'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
      else
         it.mode = MODE_W'($urandom_range(MODE_TIMER, MODE_WRITE));
      it.write_data        = REG_W'($urandom_range(255));
      it.peripheral_status = PSTAT_W'($urandom_range(3));
      it.high_request      = 1'($urandom_range(1));
      // Keep the handler mostly inactive so requests can fire
      it.in_service        = ($urandom_range(99) < 25);
      return it;
   endfunction

   // Offer one item and predict its result once accepted
   task automatic send_item(item_type it);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid             <= 1'b1;
      req_if.mode              <= it.mode;
      req_if.write_data        <= it.write_data;
      req_if.peripheral_status <= it.peripheral_status;
      req_if.high_request      <= it.high_request;
      req_if.in_service        <= it.in_service;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      expected_q.insert(expected_q.size(), predict_control(it));
   endtask

   // Drop valid, then wait for every expected result
   task automatic wait_results_drained();
      int guard;
      guard = 0;
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_q.size() != 0 && guard < DRAIN_GUARD) begin
         @(posedge clock);
         guard++;
      end
      if (expected_q.size() != 0) begin
         report_mismatch("results never arrived", 0, expected_q.size());
         expected_q.delete();
      end
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DAT_W-1:0] data);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      @(posedge clock);
      while (!csr_if.ready)
         @(posedge clock);
      case (idx)
         CSR_PRIORITY_ENABLE: prio_en_q  = data[0];
         CSR_PRIORITY_SELECT: prio_sel_q = data[PSEL_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // Reprogram both settings with the block idle
   task automatic set_priority(logic pe, logic [PSEL_W-1:0] ps);
      wait_results_drained();
      write_csr(CSR_PRIORITY_ENABLE, {1'b0, pe});
      write_csr(CSR_PRIORITY_SELECT, ps);
   endtask

   // Single-level gating, entry and return, peripheral and timer operations
   task automatic test_single_level();
      set_priority(1'b0, 2'd3);
      send_item(make_item(MODE_PERIPH, 8'h00, 2'd0, 1'b0, 1'b0));
      send_item(make_item(MODE_WRITE, 8'h00, 2'd0, 1'b0, 1'b0));
      send_item(make_item(MODE_WRITE, 8'hFF, 2'd3, 1'b1, 1'b1));
      send_item(make_item(MODE_WRITE, 8'hFF, 2'd0, 1'b0, 1'b0));
      send_item(make_item(MODE_WRITE, 8'hC0, 2'd1, 1'b0, 1'b0));
      send_item(make_item(MODE_WRITE, 8'h40, 2'd2, 1'b0, 1'b0));
      send_item(make_item(MODE_PERIPH, 8'h00, 2'd0, 1'b1, 1'b0));
      send_item(make_item(MODE_WRITE, 8'hC0, 2'd0, 1'b0, 1'b0));
      send_item(make_item(MODE_PERIPH, 8'h00, 2'd0, 1'b0, 1'b0));
      send_item(make_item(MODE_ENTRY, 8'h00, 2'd0, 1'b0, 1'b0));
      send_item(make_item(MODE_WRITE, 8'h20, 2'd0, 1'b0, 1'b0));
      send_item(make_item(MODE_TIMER, 8'h00, 2'd0, 1'b0, 1'b0));
      send_item(make_item(MODE_RETURN, 8'h00, 2'd0, 1'b0, 1'b0));
   endtask

   // Two-level vectors, entry clearing GIEH or GIEL, return re-enable order
   task automatic test_two_level();
      set_priority(1'b1, 2'd0);
      send_item(make_item(MODE_WRITE, 8'h92, 2'd0, 1'b0, 1'b0));
      send_item(make_item(MODE_ENTRY, 8'h00, 2'd0, 1'b0, 1'b0));
      send_item(make_item(MODE_RETURN, 8'h00, 2'd0, 1'b0, 1'b0));
      send_item(make_item(MODE_WRITE, 8'hE9, 2'd0, 1'b0, 1'b0));
      send_item(make_item(MODE_ENTRY, 8'h00, 2'd0, 1'b0, 1'b0));
      send_item(make_item(MODE_RETURN, 8'h00, 2'd0, 1'b0, 1'b0));
      send_item(make_item(MODE_PERIPH, 8'h00, 2'd0, 1'b1, 1'b0));
      send_item(make_item(MODE_PERIPH, 8'h00, 2'd0, 1'b0, 1'b1));
      send_item(make_item(MODE_WRITE, 8'h80, 2'd1, 1'b0, 1'b0));
      set_priority(1'b1, 2'd3);
      send_item(make_item(MODE_WRITE, 8'hE9, 2'd0, 1'b0, 1'b0));
   endtask

   // Spare mode codes leave everything as it is
   task automatic test_unused_modes();
      for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++)
         send_item(make_item(MODE_W'(m), REG_W'($urandom_range(255)),
                             PSTAT_W'($urandom_range(3)), 1'($urandom_range(1)), 1'b0));
   endtask

   // Hold the result channel while items keep coming
   task automatic test_backpressure();
      wait_results_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_len      = HOLD_CYCLES;
      hold_go       = ~hold_go;
      repeat (16) send_item(random_item());
   endtask

   // Random items in chunks, each under its own priority setting
   task automatic test_random();
      int k;
      logic pe;
      logic [PSEL_W-1:0] ps;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 17; recv_idle_pct = 62; end
            1: begin send_idle_pct = 62; recv_idle_pct = 17; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (int chunk = 0; chunk < 3; chunk++) begin
            k = phase * 3 + chunk;
            case (k)
               0: begin pe = 1'b0; ps = 2'd3; end
               1: begin pe = 1'b1; ps = 2'd0; end
               2: begin pe = 1'b1; ps = 2'd3; end
               3: begin pe = 1'b0; ps = 2'd0; end
               4: begin pe = 1'b1; ps = 2'd1; end
               5: begin pe = 1'b1; ps = 2'd2; end
               default: begin
                  pe = 1'($urandom_range(1));
                  ps = PSEL_W'($urandom_range(3));
               end
            endcase
            set_priority(pe, ps);
            repeat (50) send_item(random_item());
         end
      end
   endtask

   // Result channel ready with random stalls and requested hold-offs
   initial begin
      bit hold_seen;
      int hold_left;
      hold_seen    = 1'b0;
      hold_left    = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_go != hold_seen) begin
            hold_seen = hold_go;
            hold_left = hold_len;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Compare each result with the oldest prediction
   always @(posedge clock) begin : check_result
      result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_q.size() == 0) begin
            report_mismatch("result with nothing expected", int'(rsp_if.register_value), 0);
         end else begin
            want = expected_q.pop_front();
            if (rsp_if.register_value !== want.register_value)
               report_mismatch("register_value", int'(rsp_if.register_value),
                               int'(want.register_value));
            if (rsp_if.interrupt_request !== want.interrupt_request)
               report_mismatch("interrupt_request", int'(rsp_if.interrupt_request),
                               int'(want.interrupt_request));
            if (rsp_if.vector_high !== want.vector_high)
               report_mismatch("vector_high", int'(rsp_if.vector_high),
                               int'(want.vector_high));
         end
      end
   end

   // Main sequence
   initial begin
      reset                    = 1'b1;
      req_if.valid             = 1'b0;
      req_if.mode              = MODE_WRITE;
      req_if.write_data        = '0;
      req_if.peripheral_status = '0;
      req_if.high_request      = 1'b0;
      req_if.in_service        = 1'b0;
      csr_if.valid             = 1'b0;
      csr_if.index             = CSR_PRIORITY_ENABLE;
      csr_if.data              = '0;

      // Model matches the state after reset
      ctrl_q     = '0;
      vec_hi_q   = 1'b0;
      prio_en_q  = 1'b0;
      prio_sel_q = PSEL_RESET;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 17;
      recv_idle_pct = 62;
      test_single_level();
      test_two_level();
      test_unused_modes();
      test_backpressure();
      test_random();

      wait_results_drained();
      repeat (5) @(posedge clock);
      if (err_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
